/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME_CYCLE(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME_CYCLE(lbl, clk, rst, pre, post)
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, pre, post)
`endif
`endif

/* rtl/jtfe_pkg.sv */
// shared types and constants of the token field extractor
`default_nettype none
package jtfe_pkg;

  localparam int LENGTH_BITS = 12;
  localparam int KEY_LEN = 14;
  localparam int KEY_POS_BITS = $clog2(KEY_LEN + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int OUT_FIELD_BITS = 8 + 3 + LENGTH_BITS;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [LENGTH_BITS-1:0] CAPACITY_RESET = LENGTH_BITS'(127);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h22, 8'h61, 8'h63, 8'h63, 8'h65, 8'h73, 8'h73,
    8'h5F, 8'h74, 8'h6F, 8'h6B, 8'h65, 8'h6E, 8'h22
  };

  typedef enum logic [2:0] {
    PH_SEEK_KEY,
    PH_SEEK_COLON,
    PH_SKIP_BLANK,
    PH_VALUE,
    PH_CLOSED,
    PH_NO_QUOTE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_KEY   = 3'd1,
    ST_NO_COLON = 3'd2,
    ST_NO_QUOTE = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic                   has_byte;
    logic [7:0]             token_byte;
    logic                   has_final;
    status_t                status;
    logic [LENGTH_BITS-1:0] token_length;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/json_token_field_extractor_top.sv */
// top level of the json access token field extractor
// takes one text byte per cycle, back to back, as long as the four-entry command
// queue between the scanner and the output stage has room; a text byte gives at
// most one token word and the end word gives the final status word, preceded by a
// withheld backslash when one is pending; results leave through a registered output
// stage
`default_nettype none
module json_token_field_extractor_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,  // text_byte
  input  wire logic                                 s_tlast,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // token_byte, status, token_length, zero fill
  output logic [jtfe_pkg::OUT_DATA_BITS-1:0]        m_tdata,
  output logic                                      m_tlast,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [jtfe_pkg::LENGTH_BITS-1:0]     cfg_wr_data
);

`include "assert_macros.svh"

  jtfe_pkg::cmd_t push_cmd, head_cmd;
  logic           q_push, q_pop, q_full, q_not_empty;

  jtfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  jtfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  jtfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_cmd    (head_cmd),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  `ASSERT_SAME_CYCLE(a_final_status, clk, rst, m_tvalid && m_tlast,
    m_tdata[10:8] <= jtfe_pkg::ST_EMPTY && m_tdata[7:0] == 8'h00)
  `ASSERT_SAME_CYCLE(a_byte_word_clean, clk, rst, m_tvalid && !m_tlast,
    m_tdata[jtfe_pkg::OUT_DATA_BITS-1:8] == '0)
  `ASSERT_NEXT_CYCLE(a_end_queued, clk, rst, s_tvalid && s_tready && s_tlast,
    q_not_empty)
  `ASSERT_SAME_CYCLE(a_pop_needs_entry, clk, rst, q_pop, q_not_empty)

endmodule
`default_nettype wire

/* rtl/jtfe_front.sv */
// front: accepts text words, runs the key and value scan, issues result commands
`default_nettype none
module jtfe_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,
  input  wire logic                             s_tlast,
  input  wire logic                             cfg_wr_en,
  input  wire logic [jtfe_pkg::LENGTH_BITS-1:0] cfg_wr_data,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output jtfe_pkg::cmd_t                        q_cmd
);

  jtfe_pkg::phase_t                    phase, phase_next;
  logic [jtfe_pkg::KEY_POS_BITS-1:0]   key_pos, key_pos_next;
  logic                                esc, esc_next;
  logic [jtfe_pkg::LENGTH_BITS-1:0]    count, count_next;
  logic [jtfe_pkg::LENGTH_BITS-1:0]    capacity;
  logic                                accept;
  logic                                below_cap;
  logic                                key_hit;
  logic [jtfe_pkg::LENGTH_BITS-1:0]    count_inc;
  logic                                blank;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign below_cap = count < capacity;
  assign count_inc = count + jtfe_pkg::LENGTH_BITS'(1);
  assign key_hit   = (key_pos < jtfe_pkg::KEY_POS_BITS'(jtfe_pkg::KEY_LEN)) &&
                     (s_tdata == jtfe_pkg::KEY_TEXT[key_pos]);
  assign blank     = (s_tdata == jtfe_pkg::CH_SPACE) || (s_tdata == jtfe_pkg::CH_TAB) ||
                     (s_tdata == jtfe_pkg::CH_CR) || (s_tdata == jtfe_pkg::CH_LF);

  // result commands
  always_comb begin
    q_cmd  = '0;
    q_push = 1'b0;
    if (accept) begin
      if (s_tlast) begin
        q_cmd.has_byte   = (phase == jtfe_pkg::PH_VALUE) && esc && below_cap;
        q_cmd.token_byte = q_cmd.has_byte ? jtfe_pkg::CH_BSLASH : 8'h00;
        q_cmd.has_final  = 1'b1;
        q_cmd.token_length = q_cmd.has_byte ? count_inc : count;
        case (phase)
          jtfe_pkg::PH_SEEK_KEY:   q_cmd.status = jtfe_pkg::ST_NO_KEY;
          jtfe_pkg::PH_SEEK_COLON: q_cmd.status = jtfe_pkg::ST_NO_COLON;
          jtfe_pkg::PH_SKIP_BLANK,
          jtfe_pkg::PH_NO_QUOTE:   q_cmd.status = jtfe_pkg::ST_NO_QUOTE;
          default: begin
            q_cmd.status = (q_cmd.token_length != '0) ? jtfe_pkg::ST_OK
                                                      : jtfe_pkg::ST_EMPTY;
          end
        endcase
        q_push = 1'b1;
      end else if (phase == jtfe_pkg::PH_VALUE && below_cap &&
                   (esc || (s_tdata != jtfe_pkg::CH_QUOTE &&
                            s_tdata != jtfe_pkg::CH_BSLASH))) begin
        q_cmd.has_byte   = 1'b1;
        q_cmd.token_byte = s_tdata;
        q_push = 1'b1;
      end
    end
  end

  // scan state
  always_comb begin
    phase_next   = phase;
    key_pos_next = key_pos;
    esc_next     = esc;
    count_next   = count;
    if (accept) begin
      if (s_tlast) begin
        phase_next   = jtfe_pkg::PH_SEEK_KEY;
        key_pos_next = '0;
        esc_next     = 1'b0;
        count_next   = '0;
      end else begin
        case (phase)
          jtfe_pkg::PH_SEEK_KEY: begin
            if (key_hit) begin
              key_pos_next = key_pos + jtfe_pkg::KEY_POS_BITS'(1);
            end else begin
              key_pos_next = (s_tdata == jtfe_pkg::CH_QUOTE) ?
                             jtfe_pkg::KEY_POS_BITS'(1) : '0;
            end
            if (key_pos_next >= jtfe_pkg::KEY_POS_BITS'(jtfe_pkg::KEY_LEN)) begin
              key_pos_next = '0;
              phase_next   = jtfe_pkg::PH_SEEK_COLON;
            end
          end
          jtfe_pkg::PH_SEEK_COLON: begin
            if (s_tdata == jtfe_pkg::CH_COLON) begin
              phase_next = jtfe_pkg::PH_SKIP_BLANK;
            end
          end
          jtfe_pkg::PH_SKIP_BLANK: begin
            if (!blank) begin
              if (s_tdata == jtfe_pkg::CH_QUOTE) begin
                phase_next = below_cap ? jtfe_pkg::PH_VALUE : jtfe_pkg::PH_CLOSED;
              end else begin
                phase_next = jtfe_pkg::PH_NO_QUOTE;
              end
            end
          end
          jtfe_pkg::PH_VALUE: begin
            if (!below_cap) begin
              esc_next   = 1'b0;
              phase_next = jtfe_pkg::PH_CLOSED;
            end else if (esc) begin
              esc_next = 1'b0;
            end else if (s_tdata == jtfe_pkg::CH_QUOTE) begin
              phase_next = jtfe_pkg::PH_CLOSED;
            end else if (s_tdata == jtfe_pkg::CH_BSLASH) begin
              esc_next = 1'b1;
            end
            if (q_cmd.has_byte) begin
              count_next = count_inc;
            end
            if (phase_next == jtfe_pkg::PH_VALUE && !esc_next &&
                count_next >= capacity) begin
              phase_next = jtfe_pkg::PH_CLOSED;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= jtfe_pkg::PH_SEEK_KEY;
      key_pos  <= '0;
      esc      <= 1'b0;
      count    <= '0;
      capacity <= jtfe_pkg::CAPACITY_RESET;
    end else begin
      phase   <= phase_next;
      key_pos <= key_pos_next;
      esc     <= esc_next;
      count   <= count_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/jtfe_queue.sv */
// short command queue between the front and the back
`default_nettype none
module jtfe_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jtfe_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output jtfe_pkg::cmd_t      head_cmd,
  output logic                not_empty,
  output logic                full
);

  jtfe_pkg::cmd_t                       entries [jtfe_pkg::QUEUE_DEPTH];
  logic [jtfe_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [jtfe_pkg::QUEUE_PTR_BITS:0]    level, level_next;

  assign head_cmd  = entries[rd_ptr];
  assign not_empty = level != '0;
  assign full      = level == (jtfe_pkg::QUEUE_PTR_BITS+1)'(jtfe_pkg::QUEUE_DEPTH);

  always_comb begin
    level_next = level;
    if (push && !pop) begin
      level_next = level + (jtfe_pkg::QUEUE_PTR_BITS+1)'(1);
    end else if (pop && !push) begin
      level_next = level - (jtfe_pkg::QUEUE_PTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      level <= level_next;
      if (push) begin
        wr_ptr <= wr_ptr + jtfe_pkg::QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + jtfe_pkg::QUEUE_PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/jtfe_back.sv */
// back: turns queued commands into result words behind an output register
`default_nettype none
module jtfe_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire jtfe_pkg::cmd_t                       head_cmd,
  input  wire logic                                 q_not_empty,
  output logic                                      q_pop,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [jtfe_pkg::OUT_DATA_BITS-1:0]        m_tdata,
  output logic                                      m_tlast
);

  logic                                  byte_done, byte_done_next;
  logic                                  load;
  logic                                  send_byte;
  logic [jtfe_pkg::OUT_DATA_BITS-1:0]    data_next;

  assign load      = !m_tvalid || m_tready;
  assign send_byte = head_cmd.has_byte && !byte_done;

  always_comb begin
    q_pop          = 1'b0;
    byte_done_next = byte_done;
    data_next      = '0;
    if (load && q_not_empty) begin
      if (send_byte) begin
        data_next = jtfe_pkg::OUT_DATA_BITS'(head_cmd.token_byte);
        if (head_cmd.has_final) begin
          byte_done_next = 1'b1;
        end else begin
          q_pop = 1'b1;
        end
      end else begin
        data_next = jtfe_pkg::OUT_DATA_BITS'({head_cmd.token_length, head_cmd.status,
                                              8'h00});
        byte_done_next = 1'b0;
        q_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      byte_done <= 1'b0;
    end else begin
      byte_done <= byte_done_next;
      if (load) begin
        m_tvalid <= q_not_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_not_empty) begin
      m_tdata <= data_next;
      m_tlast <= !send_byte;
    end
  end

endmodule
`default_nettype wire
